// ----- hdl/mlj_pkg.sv -----
`timescale 1ns / 1ps

package mlj_pkg;

  typedef enum logic {
    CMD_SUBMIT = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CLS_SUBMIT = 2'd0,
    CLS_FLUSH  = 2'd1,
    CLS_REJECT = 2'd2
  } cls_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] job_tag;
    logic [22:0] job_blocks;
  } in_t;

  typedef struct packed {
    logic        done_valid;
    logic [15:0] done_job;
    logic [5:0]  done_lane;
    logic        dispatch_valid;
    logic [22:0] dispatch_blocks;
    logic [15:0] dispatch_lanes;
    logic        error;
  } out_t;

  typedef struct packed {
    cls_e        cls;
    logic [15:0] tag;
    logic [22:0] blocks;
  } item_t;

  localparam logic [4:0]  ACTIVE_LANES_RST  = 5'd16;
  localparam logic        ADDR_ACTIVE_LANES = 1'b0;
  localparam logic [7:0]  FILL_BYTE         = 8'h7f;
  localparam int unsigned GROUP_LANES       = 8;
  localparam int unsigned GRP_SHIFT         = 3;

  // Only 4, 8 or 16 lanes, and no more than max_lanes, run the scheduler; anything else leaves zero lanes.
  function automatic logic [4:0] lanes_for(logic [4:0] n, int unsigned max_lanes);
    logic ok;
    ok = (n == 5'd4 || n == 5'd8 || n == 5'd16) && (32'(n) <= max_lanes);
    return ok ? n : 5'd0;
  endfunction

endpackage

// ----- hdl/multibuffer_lane_job_scheduler.sv -----
`timescale 1ns / 1ps
// A job passes the front stage register and a two-entry queue to the lane state
// sequencer, which handles one item at a time; a dispatch adds a min-tree search.
// New jobs are taken while busy is low, so the front keeps accepting until the
// queue and the stage register are both full.
// Reset (async, active low) sets active_lanes to 16 and clears all lanes; a
// write of active_lanes reinitializes them. Results go out without back-pressure.

module multibuffer_lane_job_scheduler #(
  parameter int unsigned MAX_LANES = 16,
  parameter int unsigned LEN_BITS  = 23
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mlj_pkg::in_t  job_i,
  output logic          result_strobe_o,
  output mlj_pkg::out_t result_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic          paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [4:0]     active_q, lane_cnt_q, new_cnt;
  logic           cfg_wr;
  logic           push_vld, push_rdy, pop_vld, pop;
  mlj_pkg::item_t push_item, pop_item;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (paddr == mlj_pkg::ADDR_ACTIVE_LANES);
  assign new_cnt = mlj_pkg::lanes_for(pwdata[4:0], MAX_LANES);
  assign prdata  = (paddr == mlj_pkg::ADDR_ACTIVE_LANES) ? {27'd0, active_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= mlj_pkg::ACTIVE_LANES_RST;
      lane_cnt_q <= mlj_pkg::lanes_for(mlj_pkg::ACTIVE_LANES_RST, MAX_LANES);
    end else if (cfg_wr) begin
      active_q   <= pwdata[4:0];
      lane_cnt_q <= new_cnt;
    end
  end

  mlj_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .job_i       (job_i),
    .lane_cnt_i  (lane_cnt_q),
    .push_vld_o  (push_vld),
    .push_item_o (push_item),
    .push_rdy_i  (push_rdy)
  );

  mlj_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_vld_i  (push_vld),
    .push_item_i (push_item),
    .push_rdy_o  (push_rdy),
    .pop_vld_o   (pop_vld),
    .pop_item_o  (pop_item),
    .pop_i       (pop)
  );

  mlj_back #(
    .MAX_LANES (MAX_LANES),
    .LEN_BITS  (LEN_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_i     (cfg_wr),
    .init_cnt_i (new_cnt),
    .lane_cnt_i (lane_cnt_q),
    .item_vld_i (pop_vld),
    .item_i     (pop_item),
    .item_pop_o (pop),
    .res_vld_o  (result_strobe_o),
    .res_o      (result_o)
  );

endmodule

// ----- hdl/mlj_front.sv -----
`timescale 1ns / 1ps

module mlj_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  mlj_pkg::in_t  job_i,
  input  logic [4:0]    lane_cnt_i,
  output logic          push_vld_o,
  output mlj_pkg::item_t push_item_o,
  input  logic          push_rdy_i
);

  logic           stage_vld_q;
  mlj_pkg::item_t stage_q;
  mlj_pkg::item_t item_d;
  logic           accept;

  assign busy_o     = stage_vld_q && !push_rdy_i;
  assign accept     = start_i && !busy_o;
  assign push_vld_o = stage_vld_q;
  assign push_item_o = stage_q;

  always_comb begin
    item_d.tag    = job_i.job_tag;
    item_d.blocks = job_i.job_blocks;
    // With no lanes every command fails without touching lane state.
    if (lane_cnt_i == 5'd0) begin
      item_d.cls = mlj_pkg::CLS_REJECT;
    end else if (job_i.cmd == mlj_pkg::CMD_FLUSH) begin
      item_d.cls = mlj_pkg::CLS_FLUSH;
    end else begin
      item_d.cls = mlj_pkg::CLS_SUBMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else if (accept) begin
      stage_vld_q <= 1'b1;
    end else if (push_rdy_i) begin
      stage_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= item_d;
    end
  end

endmodule

// ----- hdl/mlj_queue.sv -----
`timescale 1ns / 1ps

module mlj_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_vld_i,
  input  mlj_pkg::item_t push_item_i,
  output logic           push_rdy_o,
  output logic           pop_vld_o,
  output mlj_pkg::item_t pop_item_o,
  input  logic           pop_i
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  mlj_pkg::item_t slot_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           push, pop;

  assign push_rdy_o = (cnt_q != CW'(DEPTH));
  assign pop_vld_o  = (cnt_q != '0);
  assign pop_item_o = slot_q[rd_ptr_q];
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_i && pop_vld_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- hdl/mlj_min_tree.sv -----
`timescale 1ns / 1ps

module mlj_min_tree #(
  parameter int unsigned N = 16,
  parameter int unsigned W = 23
) (
  input  logic                clk_i,
  input  logic [N-1:0]        vld_i,
  input  logic [N-1:0][W-1:0] val_i,
  output logic                root_vld_o,
  output logic [W-1:0]        root_o
);

  localparam int unsigned LV = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned P  = 1 << LV;

  // Key carries an invalid mark above the value so empty leaves never win.
  logic [W:0] key    [1:2*P-1];
  logic [W:0] node_q [1:P-1];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign key[P+i] = {~vld_i[i], val_i[i]};
    end else begin : g_pad
      assign key[P+i] = {1'b1, {W{1'b0}}};
    end
  end

  for (genvar n = 1; n < P; n++) begin : g_node
    assign key[n] = node_q[n];
    always_ff @(posedge clk_i) begin
      node_q[n] <= (key[2*n+1] < key[2*n]) ? key[2*n+1] : key[2*n];
    end
  end

  assign root_vld_o = ~key[1][W];
  assign root_o     = key[1][W-1:0];

endmodule

// ----- hdl/mlj_back.sv -----
`timescale 1ns / 1ps

module mlj_back #(
  parameter int unsigned MAX_LANES = 16,
  parameter int unsigned LEN_BITS  = 23
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           init_i,
  input  logic [4:0]     init_cnt_i,
  input  logic [4:0]     lane_cnt_i,
  input  logic           item_vld_i,
  input  mlj_pkg::item_t item_i,
  output logic           item_pop_o,
  output logic           res_vld_o,
  output mlj_pkg::out_t  res_o
);

  localparam int unsigned LW       = $clog2(MAX_LANES);
  localparam int unsigned NG       = (MAX_LANES + mlj_pkg::GROUP_LANES - 1) /
                                     mlj_pkg::GROUP_LANES;
  localparam int unsigned GW       = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned TREE_LAT = $clog2(MAX_LANES);
  localparam int unsigned WW       = $clog2(TREE_LAT + 1);
  localparam logic [4:0]  RST_CNT  =
    mlj_pkg::lanes_for(mlj_pkg::ACTIVE_LANES_RST, MAX_LANES);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ALLOC = 3'd1;
  localparam logic [2:0] ST_REL   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                         state_q;
  mlj_pkg::item_t                     cur_q;
  logic [MAX_LANES-1:0][LEN_BITS-1:0] len_q;
  logic [MAX_LANES-1:0]               busy_q;
  logic [NG-1:0][63:0]                stk_q;
  logic [6:0]                         busy_cnt_q;
  logic                               second_q;
  logic [WW-1:0]                      wait_q;
  logic                               err_q, done_vld_q, disp_q;
  logic [LW-1:0]                      done_lane_q;
  logic [LEN_BITS-1:0]                min_q;
  logic [15:0]                        mask_q;
  logic [15:0]                        job_mem [MAX_LANES];
  logic [15:0]                        job_rd_q;
  mlj_pkg::out_t                      res_q;
  logic                               res_vld_q;

  logic [MAX_LANES-1:0]    lane_en, zero, free, fin, cand;
  logic [MAX_LANES+15:0]   cand_ext;
  logic [LW-1:0]           free_idx, fin_idx, pop_lane;
  logic                    free_any, fin_any;
  logic [GW-1:0]           free_grp, fin_grp;
  logic [7:0]              pop_byte;
  logic                    pop_ok;
  logic                    root_vld;
  logic [LEN_BITS-1:0]     root;
  logic [LEN_BITS-1:0]     len_in;
  logic                    job_we, job_re;

  function automatic logic [LW-1:0] first_set(logic [MAX_LANES-1:0] v);
    logic [LW-1:0] idx;
    idx = '0;
    for (int i = MAX_LANES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = LW'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [63:0] init_stack(int unsigned g, logic [4:0] cnt);
    logic [63:0] s;
    int unsigned lane;
    s = '0;
    for (int unsigned k = 0; k < mlj_pkg::GROUP_LANES; k++) begin
      lane = g * mlj_pkg::GROUP_LANES + k;
      s[k*8 +: 8] = (lane < 32'(cnt)) ? 8'(lane) : mlj_pkg::FILL_BYTE;
    end
    return s;
  endfunction

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      lane_en[i] = (7'(i) < 7'(lane_cnt_i));
      zero[i]    = (len_q[i] == '0);
      free[i]    = ~busy_q[i] & zero[i] & lane_en[i];
      fin[i]     = busy_q[i] & zero[i] & lane_en[i];
      cand[i]    = busy_q[i] & ~zero[i] & lane_en[i];
    end
  end

  assign free_any = |free;
  assign fin_any  = |fin;
  assign free_idx = first_set(free);
  assign fin_idx  = first_set(fin);
  assign free_grp = GW'(free_idx >> mlj_pkg::GRP_SHIFT);
  assign fin_grp  = GW'(fin_idx >> mlj_pkg::GRP_SHIFT);
  assign pop_byte = stk_q[free_grp][7:0];
  assign pop_ok   = (pop_byte < 8'(lane_cnt_i));
  assign pop_lane = LW'(pop_byte);
  assign len_in   = LEN_BITS'(cur_q.blocks);
  assign cand_ext = (MAX_LANES + 16)'(cand);

  assign item_pop_o = (state_q == ST_IDLE) && !init_i;
  assign job_we     = (state_q == ST_ALLOC) && free_any && pop_ok && !init_i;
  assign job_re     = (state_q == ST_REL) && fin_any && !init_i;
  assign res_vld_o  = res_vld_q;
  assign res_o      = res_q;

  mlj_min_tree #(
    .N (MAX_LANES),
    .W (LEN_BITS)
  ) u_tree (
    .clk_i      (clk_i),
    .vld_i      (cand),
    .val_i      (len_q),
    .root_vld_o (root_vld),
    .root_o     (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      busy_q      <= '0;
      busy_cnt_q  <= '0;
      for (int unsigned g = 0; g < NG; g++) begin
        stk_q[g] <= init_stack(g, RST_CNT);
      end
      second_q    <= 1'b0;
      wait_q      <= '0;
      err_q       <= 1'b0;
      done_vld_q  <= 1'b0;
      disp_q      <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      res_vld_q <= 1'b0;
      if (init_i) begin
        len_q      <= '0;
        busy_q     <= '0;
        busy_cnt_q <= '0;
        for (int unsigned g = 0; g < NG; g++) begin
          stk_q[g] <= init_stack(g, init_cnt_i);
        end
      end else begin
        unique case (state_q)
          ST_IDLE: begin
            if (item_vld_i) begin
              err_q      <= 1'b0;
              done_vld_q <= 1'b0;
              disp_q     <= 1'b0;
              second_q   <= 1'b0;
              unique case (item_i.cls)
                mlj_pkg::CLS_SUBMIT: state_q <= ST_ALLOC;
                mlj_pkg::CLS_FLUSH:  state_q <= ST_REL;
                default: begin
                  err_q   <= 1'b1;
                  state_q <= ST_DONE;
                end
              endcase
            end
          end
          ST_ALLOC: begin
            if (!free_any || !pop_ok) begin
              err_q   <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              len_q[pop_lane]  <= len_in;
              busy_q[pop_lane] <= 1'b1;
              stk_q[free_grp]  <= {8'h00, stk_q[free_grp][63:8]};
              busy_cnt_q       <= busy_cnt_q + 7'd1;
              state_q          <= ST_REL;
            end
          end
          ST_REL: begin
            wait_q <= '0;
            if (fin_any) begin
              // Push the freed lane back on its group stack.
              stk_q[fin_grp]  <= {stk_q[fin_grp][55:0], 8'(fin_idx)};
              busy_q[fin_idx] <= 1'b0;
              busy_cnt_q      <= busy_cnt_q - 7'd1;
              done_vld_q      <= 1'b1;
              done_lane_q     <= fin_idx;
              state_q         <= ST_DONE;
            end else if (second_q) begin
              state_q <= ST_DONE;
            end else if (cur_q.cls == mlj_pkg::CLS_SUBMIT) begin
              if (busy_cnt_q >= 7'(lane_cnt_i) && busy_cnt_q != '0) begin
                state_q <= ST_SCAN;
              end else begin
                state_q <= ST_DONE;
              end
            end else if (busy_cnt_q == '0) begin
              err_q   <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_SCAN;
            end
          end
          ST_SCAN: begin
            wait_q <= wait_q + WW'(1);
            // Hold until the min tree has settled on the current lane state.
            if (wait_q == WW'(TREE_LAT)) begin
              if (root_vld) begin
                for (int i = 0; i < MAX_LANES; i++) begin
                  if (cand[i]) begin
                    len_q[i] <= len_q[i] - root;
                  end
                end
                mask_q   <= cand_ext[15:0];
                min_q    <= root;
                disp_q   <= 1'b1;
                second_q <= 1'b1;
                state_q  <= ST_REL;
              end else begin
                err_q   <= (cur_q.cls == mlj_pkg::CLS_FLUSH);
                state_q <= ST_DONE;
              end
            end
          end
          ST_DONE: begin
            res_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o && item_vld_i) begin
      cur_q <= item_i;
    end
    if (state_q == ST_DONE) begin
      res_q.done_valid      <= done_vld_q;
      res_q.done_job        <= done_vld_q ? job_rd_q : 16'h0000;
      res_q.done_lane       <= done_vld_q ? 6'(done_lane_q) : 6'd0;
      res_q.dispatch_valid  <= disp_q;
      res_q.dispatch_blocks <= disp_q ? 23'(min_q) : 23'd0;
      res_q.dispatch_lanes  <= disp_q ? mask_q : 16'h0000;
      res_q.error           <= err_q;
    end
  end

  // Lane job tags: one write port at allocation, one read port at release.
  always_ff @(posedge clk_i) begin
    if (job_we) begin
      job_mem[pop_lane] <= cur_q.tag;
    end
    if (job_re) begin
      job_rd_q <= job_mem[fin_idx];
    end
  end

  a_res_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> $past(state_q) == ST_DONE)
    else $error("result beat without a finished item");

  a_scan_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && !$past(init_i) |-> $stable(busy_q) && $stable(len_q))
    else $error("lane state moved during min search");

  a_disp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && disp_q |-> (min_q != '0) && (mask_q != '0))
    else $error("dispatch with empty lane set or zero length");

  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && err_q |-> !done_vld_q && !disp_q)
    else $error("error reported together with completion or dispatch");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

  typedef enum logic {
    ROW_JOB = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_e;

  typedef struct {
    row_kind_e     kind;
    logic [4:0]    lanes;
    mlj_pkg::in_t  job;
    bit            typed;
    mlj_pkg::out_t outcome;
  } row_t;

  localparam mlj_pkg::out_t OUT_NONE = '0;
  localparam mlj_pkg::out_t OUT_ERR  = '{error: 1'b1, default: '0};
  localparam int            DRAIN_CYCLES = 16;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          start;
  logic          busy;
  mlj_pkg::in_t  job_i;
  logic          result_strobe_o;
  mlj_pkg::out_t result_o;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic          paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  multibuffer_lane_job_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .job_i          (job_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // Lane scheduler state as the block should hold it
  int          lane_cnt;
  int          n_busy;
  logic [22:0] len_q   [16];
  logic [15:0] tag_q   [16];
  bit          busy_q  [16];
  logic [63:0] stack_q [2];

  mlj_pkg::out_t step_outcomes_q[$];
  row_t          dir_rows[$];
  int            fail_cnt = 0;

  function automatic void lanes_init(logic [4:0] n);
    lane_cnt = (n == 5'd4 || n == 5'd8 || n == 5'd16) ? int'(n) : 0;
    for (int g = 0; g < 2; g++) begin
      for (int k = 0; k < 8; k++) begin
        stack_q[g][8*k +: 8] = (g * 8 + k < lane_cnt) ? 8'(g * 8 + k)
                                                      : mlj_pkg::FILL_BYTE;
      end
    end
    for (int i = 0; i < 16; i++) begin
      len_q[i]  = '0;
      tag_q[i]  = '0;
      busy_q[i] = 1'b0;
    end
    n_busy = 0;
  endfunction

  // Free the lowest lane whose job has run out; -1 if none.
  function automatic int release_finished();
    int lane;
    lane = -1;
    for (int i = 0; i < lane_cnt; i++) begin
      if (lane < 0 && busy_q[i] && len_q[i] == '0) begin
        lane = i;
      end
    end
    if (lane >= 0) begin
      stack_q[lane / 8] = {stack_q[lane / 8][55:0], 8'(lane)};
      busy_q[lane] = 1'b0;
      n_busy--;
    end
    return lane;
  endfunction

  // Run the shortest remaining length on every unfinished lane.
  function automatic bit run_min(output logic [22:0] blk, output logic [15:0] msk);
    bit any;
    any = 1'b0;
    blk = '0;
    msk = '0;
    if (n_busy == 0) return 1'b0;
    for (int i = 0; i < lane_cnt; i++) begin
      if (busy_q[i] && len_q[i] != '0 && (!any || len_q[i] < blk)) begin
        blk = len_q[i];
        any = 1'b1;
      end
    end
    if (!any) return 1'b0;
    for (int i = 0; i < lane_cnt; i++) begin
      if (busy_q[i] && len_q[i] != '0) begin
        len_q[i] = len_q[i] - blk;
        msk[i] = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic mlj_pkg::out_t schedule_step(mlj_pkg::in_t it);
    mlj_pkg::out_t o;
    int            done;
    int            first;
    int            g;
    logic [7:0]    pick;
    bit            disp;
    logic [22:0]   blk;
    logic [15:0]   msk;
    o = '0;
    done = -1;
    disp = 1'b0;
    blk = '0;
    msk = '0;
    if (it.cmd == mlj_pkg::CMD_SUBMIT) begin
      first = -1;
      for (int i = 0; i < lane_cnt; i++) begin
        if (first < 0 && !busy_q[i] && len_q[i] == '0) first = i;
      end
      if (first < 0) begin
        o.error = 1'b1;
      end else begin
        g = first / 8;
        pick = stack_q[g][7:0];
        if (int'(pick) >= lane_cnt) begin
          o.error = 1'b1;
        end else begin
          len_q[pick]  = it.job_blocks;
          tag_q[pick]  = it.job_tag;
          busy_q[pick] = 1'b1;
          stack_q[g]   = stack_q[g] >> 8;
          n_busy++;
          done = release_finished();
          if (done < 0 && n_busy >= lane_cnt) begin
            disp = run_min(blk, msk);
            done = release_finished();
          end
        end
      end
    end else begin
      done = release_finished();
      if (done < 0) begin
        disp = run_min(blk, msk);
        if (!disp) o.error = 1'b1;
        else done = release_finished();
      end
    end
    if (done >= 0) begin
      o.done_valid = 1'b1;
      o.done_job   = tag_q[done];
      o.done_lane  = 6'(done);
    end
    if (disp) begin
      o.dispatch_valid  = 1'b1;
      o.dispatch_blocks = blk;
      o.dispatch_lanes  = msk;
    end
    return o;
  endfunction

  function automatic void check_outcome(mlj_pkg::out_t exp_o, mlj_pkg::out_t got);
    if (got.done_valid !== exp_o.done_valid) begin
      $error("done_valid: expected %0h, got %0h", exp_o.done_valid, got.done_valid);
      fail_cnt++;
    end
    if (got.done_job !== exp_o.done_job) begin
      $error("done_job: expected %0h, got %0h", exp_o.done_job, got.done_job);
      fail_cnt++;
    end
    if (got.done_lane !== exp_o.done_lane) begin
      $error("done_lane: expected %0h, got %0h", exp_o.done_lane, got.done_lane);
      fail_cnt++;
    end
    if (got.dispatch_valid !== exp_o.dispatch_valid) begin
      $error("dispatch_valid: expected %0h, got %0h", exp_o.dispatch_valid,
             got.dispatch_valid);
      fail_cnt++;
    end
    if (got.dispatch_blocks !== exp_o.dispatch_blocks) begin
      $error("dispatch_blocks: expected %0h, got %0h", exp_o.dispatch_blocks,
             got.dispatch_blocks);
      fail_cnt++;
    end
    if (got.dispatch_lanes !== exp_o.dispatch_lanes) begin
      $error("dispatch_lanes: expected %0h, got %0h", exp_o.dispatch_lanes,
             got.dispatch_lanes);
      fail_cnt++;
    end
    if (got.error !== exp_o.error) begin
      $error("error: expected %0h, got %0h", exp_o.error, got.error);
      fail_cnt++;
    end
  endfunction

  function automatic row_t job_row(mlj_pkg::cmd_e c, logic [15:0] tag,
                                   logic [22:0] blocks, bit typed = 1'b0,
                                   mlj_pkg::out_t given = '0);
    row_t r;
    r.kind    = ROW_JOB;
    r.lanes   = '0;
    r.job     = '{c, tag, blocks};
    r.typed   = typed;
    r.outcome = given;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [4:0] n);
    row_t r;
    r.kind    = ROW_CFG;
    r.lanes   = n;
    r.job     = '0;
    r.typed   = 1'b0;
    r.outcome = '0;
    return r;
  endfunction

  function automatic mlj_pkg::in_t rand_job();
    mlj_pkg::in_t it;
    int           sel;
    it.cmd     = ($urandom_range(0, 4) == 0) ? mlj_pkg::CMD_FLUSH : mlj_pkg::CMD_SUBMIT;
    it.job_tag = 16'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 7)       it.job_blocks = 23'($urandom_range(0, 20));
    else if (sel < 9)  it.job_blocks = 23'($urandom_range(0, 4095));
    else               it.job_blocks = 23'($urandom);
    return it;
  endfunction

  // Hold start and the job until the beat is taken, then log the outcome.
  task automatic send_job(mlj_pkg::in_t it, bit typed = 1'b0,
                          mlj_pkg::out_t given = '0);
    mlj_pkg::out_t p;
    @(negedge clk_i);
    start <= 1'b1;
    job_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    p = schedule_step(it);
    step_outcomes_q.push_back(typed ? given : p);
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (step_outcomes_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_lanes(logic [4:0] n);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mlj_pkg::ADDR_ACTIVE_LANES;
    pwdata  <= {27'($urandom), n};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    lanes_init(n);
    // read back right after the write
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata[4:0] !== n) begin
      $error("active_lanes: expected %0h, got %0h", n, prdata[4:0]);
      fail_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_strobe_o === 1'b1) begin
      if (step_outcomes_q.size() == 0) begin
        $error("result beat with no job outstanding");
        fail_cnt++;
      end else begin
        check_outcome(step_outcomes_q.pop_front(), result_o);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [4:0] plan [7];
    logic [4:0] lanes;
    int         left;
    int         burst;
    plan = '{5'd16, 5'd8, 5'd4, 5'd16, 5'd0, 5'd8, 5'd0};
    rst_ni  = 1'b0;
    start   = 1'b0;
    job_i   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = 1'b0;
    pwdata  = '0;
    lanes_init(mlj_pkg::ACTIVE_LANES_RST);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // nothing active yet, then zero-length and full-length jobs on lane 0
    dir_rows.push_back(job_row(mlj_pkg::CMD_FLUSH, 16'h0000, 23'h0, 1'b1, OUT_ERR));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'h0000, 23'h0, 1'b1,
                               '{done_valid: 1'b1, default: '0}));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'hffff, 23'h7fffff, 1'b1,
                               OUT_NONE));
    dir_rows.push_back(job_row(mlj_pkg::CMD_FLUSH, 16'h0000, 23'h0, 1'b1,
                               '{done_valid: 1'b1, done_job: 16'hffff, done_lane: 6'd0,
                                 dispatch_valid: 1'b1, dispatch_blocks: 23'h7fffff,
                                 dispatch_lanes: 16'h0001, error: 1'b0}));
    dir_rows.push_back(job_row(mlj_pkg::CMD_FLUSH, 16'h0000, 23'h0, 1'b1, OUT_ERR));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'h1111, 23'd3));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'h2222, 23'd1));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'h3333, 23'd0));
    dir_rows.push_back(job_row(mlj_pkg::CMD_FLUSH, 16'h0000, 23'h0));
    dir_rows.push_back(job_row(mlj_pkg::CMD_FLUSH, 16'hffff, 23'h7fffff));
    // four lanes: the fourth submit fills them and forces a dispatch
    dir_rows.push_back(cfg_row(5'd4));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'ha5a5, 23'd5));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'h5a5a, 23'd2));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'h0001, 23'h7fffff));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'h8000, 23'd2));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'h00ff, 23'd0));
    dir_rows.push_back(job_row(mlj_pkg::CMD_FLUSH, 16'h0000, 23'h0));
    dir_rows.push_back(job_row(mlj_pkg::CMD_FLUSH, 16'h0000, 23'h0));
    dir_rows.push_back(job_row(mlj_pkg::CMD_FLUSH, 16'h0000, 23'h0));
    // scheduler disabled: everything is rejected
    dir_rows.push_back(cfg_row(5'd0));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'h1234, 23'd7, 1'b1, OUT_ERR));
    dir_rows.push_back(job_row(mlj_pkg::CMD_FLUSH, 16'h0000, 23'h0, 1'b1, OUT_ERR));
    dir_rows.push_back(cfg_row(5'd31));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'h4321, 23'd1, 1'b1, OUT_ERR));
    dir_rows.push_back(cfg_row(5'd8));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'h0f0f, 23'd9));
    dir_rows.push_back(job_row(mlj_pkg::CMD_SUBMIT, 16'hf0f0, 23'd4));
    dir_rows.push_back(job_row(mlj_pkg::CMD_FLUSH, 16'h0000, 23'h0));

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_lanes(dir_rows[r].lanes);
      end else begin
        send_job(dir_rows[r].job, dir_rows[r].typed, dir_rows[r].outcome);
        hold_off($urandom_range(0, 2));
      end
    end

    for (int p = 0; p < 7; p++) begin
      lanes = (p == 6) ? 5'($urandom_range(0, 31)) : plan[p];
      write_lanes(lanes);
      left = (lanes == 5'd4 || lanes == 5'd8 || lanes == 5'd16) ? 130 : 20;
      while (left > 0) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && left > 0; b++) begin
          send_job(rand_job());
          left--;
        end
        if ($urandom_range(0, 9) == 0) wait_drained();
        else hold_off($urandom_range(0, 6));
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    for (int w = 0; w < 2000 && step_outcomes_q.size() != 0; w++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (step_outcomes_q.size() != 0) begin
      $error("%0d results never arrived", step_outcomes_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
